// File: rtl/core/gmt_pkg.sv
`default_nettype none
package gmt_pkg;

    localparam int IdW    = 32;
    localparam int PortW  = 16;
    localparam int BeatW  = 32;
    localparam int StampW = 32;

    typedef enum logic [1:0] {
        CMD_GOSSIP    = 2'd0,
        CMD_JOIN_REP  = 2'd1,
        CMD_JOIN_REQ  = 2'd2,
        CMD_TICK      = 2'd3
    } cmd_t;

    localparam logic KIND_DUMP   = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [2:0] REG_SELF_ID   = 3'd0;
    localparam logic [2:0] REG_SELF_PORT = 3'd1;
    localparam logic [2:0] REG_PERIOD    = 3'd2;
    localparam logic [2:0] REG_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_IN_GROUP  = 3'd4;

    typedef struct packed {
        logic [IdW-1:0]    id;
        logic [PortW-1:0]  port;
        logic [BeatW-1:0]  beat;
        logic [StampW-1:0] stamp;
    } slot_t;

    // Configuration values handed to the sequencer
    typedef struct packed {
        logic [IdW-1:0]   self_id;
        logic [PortW-1:0] self_port;
        logic [7:0]       period;
        logic [15:0]      timeout;
    } cfg_t;

endpackage
`default_nettype wire

// File: rtl/core/gmt_slot_ram.sv
`default_nettype none
module gmt_slot_ram
    import gmt_pkg::*;
#(
    parameter int Depth = 32,
    parameter int AddrW = 5
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  var  slot_t            wdata,
    input  wire logic [AddrW-1:0] raddr,
    output slot_t                 rdata
);

    slot_t mem [Depth];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/gmt_regs.sv
`default_nettype none
module gmt_regs
    import gmt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output cfg_t             cfg,
    output logic             period_wr,
    output logic             group_wr,
    output logic             group_val
);

    logic [IdW-1:0]   self_id_reg;
    logic [PortW-1:0] self_port_reg;
    logic [7:0]       period_reg;
    logic [15:0]      timeout_reg;
    logic             start_reg;
    logic             wr;
    logic [2:0]       idx;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[4:2];

    // Capture register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg   <= '0;
            self_port_reg <= '0;
            period_reg    <= 8'd5;
            timeout_reg   <= 16'd20;
            start_reg     <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                REG_SELF_ID:   self_id_reg   <= pwdata;
                REG_SELF_PORT: self_port_reg <= pwdata[15:0];
                REG_PERIOD:    period_reg    <= pwdata[7:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[15:0];
                REG_IN_GROUP:  start_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign period_wr = wr && (idx == REG_PERIOD);
    assign group_wr  = wr && (idx == REG_IN_GROUP);
    assign group_val = pwdata[0];
    assign cfg = '{self_id: self_id_reg, self_port: self_port_reg,
                   period: period_reg, timeout: timeout_reg};

    // Read back
    always_comb
    begin
        case (idx)
            REG_SELF_ID:   prdata = self_id_reg;
            REG_SELF_PORT: prdata = {16'd0, self_port_reg};
            REG_PERIOD:    prdata = {24'd0, period_reg};
            REG_TIMEOUT:   prdata = {16'd0, timeout_reg};
            REG_IN_GROUP:  prdata = {31'd0, start_reg};
            default:       prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/gossip_membership_table_unit.sv
// Channel | handshake          | payload
// in      | in_valid/in_ready  | command, node_id, node_port, beat_count
// out     | out_valid/out_ready| record_kind, entry_id, entry_port, entry_beat, final_record
// cfg     | APB psel/penable   | paddr, pwdata, prdata
// One transaction at a time. A merge or join lookup scans the used slots (read, then
// compare) until a hit; a dump walks the table the same way, one record per slot; a sweep
// emits one per stale slot, and a removal compacts the table by copying each later slot down.
// Each record waits one record in a staging register so the last one can carry
// final_record; the command closes when the staged record moves out. Output stalls hold
// the walk. Reset is asynchronous; only slots below the fill count are ever used.
`default_nettype none
module gossip_membership_table_unit
    import gmt_pkg::*;
#(
    parameter int TABLE_SLOTS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] node_id,
    input  wire logic [15:0] node_port,
    input  wire logic [31:0] beat_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             record_kind,
    output logic [31:0]      entry_id,
    output logic [15:0]      entry_port,
    output logic [31:0]      entry_beat,
    output logic             final_record
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_SLOTS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FRD   = 10'b0000000010, // lookup read issued
        S_FCMP  = 10'b0000000100, // lookup compare
        S_FDONE = 10'b0000001000, // lookup result, act
        S_DRD   = 10'b0000010000, // dump read issued
        S_DOUT  = 10'b0000100000, // dump record out
        S_WRD   = 10'b0001000000, // sweep read issued
        S_WCHK  = 10'b0010000000, // sweep check / emit
        S_MRD   = 10'b0100000000, // compaction read
        S_MWR   = 10'b1000000000  // compaction write
    } st_t;

    cfg_t       cfg;
    logic       period_wr, group_wr, group_val;

    gmt_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .cfg, .period_wr, .group_wr, .group_val
    );
    assign pready = 1'b1;

    st_t              st_reg;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    mv_reg;
    logic [31:0]      time_reg, own_reg;
    logic [7:0]       cnt_reg;
    logic             grp_reg;
    logic [1:0]       cmd_reg;
    logic [31:0]      id_reg, beat_reg;
    logic [15:0]      port_reg;
    logic             self_pass_reg; // join: second lookup for self entry
    logic             found_reg;
    logic [AW-1:0]    hit_reg;
    slot_t            hit_slot_reg;
    logic             ov_reg;

    // Staged record waiting for its successor or for the end of the command
    logic             hold_v_reg;
    logic             hold_kind_reg;
    logic [31:0]      hold_id_reg, hold_beat_reg;
    logic [15:0]      hold_port_reg;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    slot_t            wdata, rdata;

    gmt_slot_ram #(.Depth(TABLE_SLOTS), .AddrW(AW)) u_ram (
        .clk, .we, .waddr, .wdata, .raddr, .rdata
    );

    logic [31:0] age;
    logic        is_self, key_hit, out_free, remove_hit;
    logic        emit_ok, rec_push, rec_flush, rec_kind;
    logic [31:0] rec_beat;
    logic [31:0] look_id;
    logic [15:0] look_port;

    assign out_free   = !out_valid || out_ready;
    assign look_id    = self_pass_reg ? cfg.self_id : id_reg;
    assign look_port  = self_pass_reg ? cfg.self_port : port_reg;
    assign key_hit    = rdata.id == look_id && rdata.port == look_port;
    assign is_self    = rdata.id == cfg.self_id && rdata.port == cfg.self_port;
    assign age        = time_reg - rdata.stamp;
    assign remove_hit = !is_self && age > {16'd0, cfg.timeout};
    assign in_ready   = st_reg == S_IDLE;
    assign out_valid  = ov_reg;

    // Record push into staging and end-of-command flush
    assign emit_ok   = !hold_v_reg || out_free;
    assign rec_push  = emit_ok && ((st_reg == S_DOUT && idx_reg < fill_reg) ||
                                   (st_reg == S_WCHK && remove_hit));
    assign rec_flush = hold_v_reg && out_free && idx_reg >= fill_reg &&
                       ((st_reg == S_DOUT && cmd_reg != CMD_TICK) || st_reg == S_WRD);
    assign rec_kind  = (st_reg == S_WCHK) ? KIND_REMOVE : KIND_DUMP;
    assign rec_beat  = (st_reg == S_DOUT && is_self) ? own_reg : rdata.beat;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; fill_reg <= '0; idx_reg <= '0; mv_reg <= '0;
            time_reg <= '1; own_reg <= '0; cnt_reg <= 8'd5; grp_reg <= 1'b0;
            self_pass_reg <= 1'b0; found_reg <= 1'b0;
            cmd_reg <= CMD_GOSSIP; hit_reg <= '0;
            id_reg <= '0; port_reg <= '0; beat_reg <= '0; hit_slot_reg <= '0;
        end
        else
        begin
            if (period_wr)
                cnt_reg <= pwdata[7:0];
            if (group_wr)
                grp_reg <= group_val;
            case (st_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= command; id_reg <= node_id;
                        port_reg <= node_port; beat_reg <= beat_count;
                        self_pass_reg <= 1'b0; found_reg <= 1'b0;
                        idx_reg <= '0;
                        if (command == CMD_TICK)
                        begin
                            if (grp_reg)
                            begin
                                if (cnt_reg == 8'd0)
                                begin
                                    own_reg <= own_reg + 32'd1;
                                    cnt_reg <= cfg.period;
                                    st_reg  <= S_DRD;
                                end
                                else
                                begin
                                    cnt_reg <= cnt_reg - 8'd1;
                                    st_reg  <= S_WRD;
                                end
                            end
                        end
                        else
                        begin
                            if (command == CMD_JOIN_REP)
                                grp_reg <= 1'b1;
                            st_reg <= S_FRD;
                        end
                    end
                end
                S_FRD:
                    st_reg <= (idx_reg < fill_reg && !found_reg) ? S_FCMP : S_FDONE;
                S_FCMP:
                begin
                    if (key_hit)
                    begin
                        found_reg <= 1'b1; hit_reg <= idx_reg[AW-1:0];
                        hit_slot_reg <= rdata;
                    end
                    idx_reg <= idx_reg + CW'(1);
                    st_reg  <= S_FRD;
                end
                S_FDONE:
                begin
                    idx_reg <= '0; found_reg <= 1'b0;
                    if (!found_reg && fill_reg != FULL)
                        fill_reg <= fill_reg + CW'(1);
                    if (cmd_reg == CMD_JOIN_REQ && !self_pass_reg)
                    begin
                        self_pass_reg <= 1'b1;
                        st_reg <= S_FRD;
                    end
                    else if (cmd_reg == CMD_JOIN_REQ)
                        st_reg <= S_DRD;
                    else
                        st_reg <= S_IDLE;
                end
                S_DRD:
                    st_reg <= S_DOUT;
                S_DOUT:
                begin
                    if (idx_reg >= fill_reg)
                    begin
                        if (cmd_reg == CMD_TICK)
                        begin
                            idx_reg <= '0;
                            st_reg <= S_WRD;
                        end
                        else if (emit_ok)
                            st_reg <= S_IDLE;
                    end
                    else if (emit_ok)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        st_reg <= S_DRD;
                    end
                end
                S_WRD:
                begin
                    if (idx_reg >= fill_reg)
                    begin
                        // close the tick once the staged record can leave
                        if (emit_ok)
                        begin
                            time_reg <= time_reg + 32'd1;
                            st_reg <= S_IDLE;
                        end
                    end
                    else
                        st_reg <= S_WCHK;
                end
                S_WCHK:
                begin
                    if (remove_hit)
                    begin
                        if (emit_ok)
                        begin
                            mv_reg <= idx_reg;
                            st_reg <= S_MRD;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        st_reg <= S_WRD;
                    end
                end
                S_MRD:
                begin
                    if (mv_reg + CW'(1) >= fill_reg)
                    begin
                        fill_reg <= fill_reg - CW'(1);
                        st_reg <= S_WRD;
                    end
                    else
                        st_reg <= S_MWR;
                end
                S_MWR:
                begin
                    mv_reg <= mv_reg + CW'(1);
                    st_reg <= S_MRD;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Stage each record, move the previous one to the output register, flush the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0; hold_v_reg <= 1'b0; hold_kind_reg <= KIND_DUMP;
            hold_id_reg <= '0; hold_port_reg <= '0; hold_beat_reg <= '0;
            record_kind <= KIND_DUMP; entry_id <= '0; entry_port <= '0;
            entry_beat <= '0; final_record <= 1'b0;
        end
        else if (rec_push)
        begin
            hold_v_reg <= 1'b1; hold_kind_reg <= rec_kind;
            hold_id_reg <= rdata.id; hold_port_reg <= rdata.port;
            hold_beat_reg <= rec_beat;
            if (hold_v_reg)
            begin
                ov_reg <= 1'b1;
                record_kind <= hold_kind_reg; entry_id <= hold_id_reg;
                entry_port <= hold_port_reg; entry_beat <= hold_beat_reg;
                final_record <= 1'b0;
            end
            else if (out_valid && out_ready)
                ov_reg <= 1'b0;
        end
        else if (rec_flush)
        begin
            hold_v_reg <= 1'b0; ov_reg <= 1'b1;
            record_kind <= hold_kind_reg; entry_id <= hold_id_reg;
            entry_port <= hold_port_reg; entry_beat <= hold_beat_reg;
            final_record <= 1'b1;
        end
        else if (out_valid && out_ready)
            ov_reg <= 1'b0;
    end

    // Memory address and write selection
    always_comb
    begin
        we = 1'b0; waddr = '0; wdata = hit_slot_reg; raddr = idx_reg[AW-1:0];
        case (st_reg)
            S_FDONE:
            begin
                if (!found_reg && fill_reg != FULL)
                begin
                    we = 1'b1; waddr = fill_reg[AW-1:0];
                    wdata = '{id: look_id, port: look_port,
                              beat: self_pass_reg ? own_reg : beat_reg,
                              stamp: time_reg};
                end
                else if (found_reg && cmd_reg != CMD_JOIN_REQ &&
                         (time_reg - hit_slot_reg.stamp) <= {17'd0, cfg.timeout[15:1]} &&
                         hit_slot_reg.beat < beat_reg)
                begin
                    we = 1'b1; waddr = hit_reg;
                    wdata = '{id: hit_slot_reg.id, port: hit_slot_reg.port,
                              beat: beat_reg, stamp: time_reg};
                end
            end
            S_MRD:
                raddr = AW'(mv_reg + CW'(1));
            S_MWR:
            begin
                we = 1'b1; waddr = mv_reg[AW-1:0]; wdata = rdata;
                raddr = AW'(mv_reg + CW'(1));
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: sim/gossip_membership_table_unit_tb.sv
`default_nettype none
module gossip_membership_table_unit_tb;
    import gmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 32;
    localparam int SETTLE_CYC  = 3000;
    localparam int DRAIN_LIMIT = 200000;

    typedef struct {
        logic        kind;
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] beat;
        logic        last_rec;
    } record_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [31:0] node_id;
    logic [15:0] node_port;
    logic [31:0] beat_count;
    logic        out_valid;
    logic        out_ready;
    logic        record_kind;
    logic [31:0] entry_id;
    logic [15:0] entry_port;
    logic [31:0] entry_beat;
    logic        final_record;

    // Shadow membership table and settings
    logic [31:0] tb_id    [SLOTS];
    logic [15:0] tb_port  [SLOTS];
    logic [31:0] tb_beat  [SLOTS];
    logic [31:0] tb_stamp [SLOTS];
    int          tb_fill;
    logic [31:0] tb_time;
    logic [31:0] tb_own_beat;
    logic [7:0]  tb_countdown;
    logic        tb_in_group;
    logic [31:0] cfg_self_id;
    logic [15:0] cfg_self_port;
    logic [7:0]  cfg_period;
    logic [15:0] cfg_timeout;

    record_t     pending_records[$];
    int          err_count;
    bit          no_idle;

    // Node pool that makes lookups hit
    logic [31:0] pool_id   [8];
    logic [15:0] pool_port [8];

    gossip_membership_table_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .node_id(node_id), .node_port(node_port), .beat_count(beat_count),
        .out_valid(out_valid), .out_ready(out_ready), .record_kind(record_kind),
        .entry_id(entry_id), .entry_port(entry_port), .entry_beat(entry_beat),
        .final_record(final_record)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int find_node(logic [31:0] id, logic [15:0] port);
        for (int i = 0; i < tb_fill; i++)
            if (tb_id[i] == id && tb_port[i] == port)
                return i;
        return -1;
    endfunction

    function automatic void add_node(logic [31:0] id, logic [15:0] port, logic [31:0] beat);
        if (tb_fill >= SLOTS)
            return;
        tb_id[tb_fill]    = id;
        tb_port[tb_fill]  = port;
        tb_beat[tb_fill]  = beat;
        tb_stamp[tb_fill] = tb_time;
        tb_fill++;
    endfunction

    function automatic bit is_own(int i);
        return tb_id[i] == cfg_self_id && tb_port[i] == cfg_self_port;
    endfunction

    function automatic void push_record(logic kind, int i, logic [31:0] beat);
        record_t r;
        r.kind     = kind;
        r.id       = tb_id[i];
        r.port     = tb_port[i];
        r.beat     = beat;
        r.last_rec = 1'b0;
        pending_records.push_back(r);
    endfunction

    function automatic int dump_members();
        for (int i = 0; i < tb_fill; i++)
            push_record(KIND_DUMP, i, is_own(i) ? tb_own_beat : tb_beat[i]);
        return tb_fill;
    endfunction

    // Advance the shadow table by one command and queue its records
    function automatic void predict_membership(cmd_t cmd, logic [31:0] id,
                                               logic [15:0] port, logic [31:0] beat);
        int n;
        int k;
        int i;
        n = 0;
        if (cmd == CMD_GOSSIP || cmd == CMD_JOIN_REP) begin
            k = find_node(id, port);
            if (k < 0)
                add_node(id, port, beat);
            else if ((tb_time - tb_stamp[k]) <= {16'd0, cfg_timeout >> 1} &&
                     tb_beat[k] < beat) begin
                tb_beat[k]  = beat;
                tb_stamp[k] = tb_time;
            end
            if (cmd == CMD_JOIN_REP)
                tb_in_group = 1'b1;
        end else if (cmd == CMD_JOIN_REQ) begin
            if (find_node(id, port) < 0)
                add_node(id, port, beat);
            if (find_node(cfg_self_id, cfg_self_port) < 0)
                add_node(cfg_self_id, cfg_self_port, tb_own_beat);
            n = dump_members();
        end else if (tb_in_group) begin
            if (tb_countdown == 8'd0) begin
                tb_own_beat++;
                n = dump_members();
                tb_countdown = cfg_period;
            end else begin
                tb_countdown--;
            end
            i = 0;
            while (i < tb_fill) begin
                if (!is_own(i) && (tb_time - tb_stamp[i]) > {16'd0, cfg_timeout}) begin
                    push_record(KIND_REMOVE, i, tb_beat[i]);
                    n++;
                    for (int j = i; j + 1 < tb_fill; j++) begin
                        tb_id[j]    = tb_id[j + 1];
                        tb_port[j]  = tb_port[j + 1];
                        tb_beat[j]  = tb_beat[j + 1];
                        tb_stamp[j] = tb_stamp[j + 1];
                    end
                    tb_fill--;
                end else begin
                    i++;
                end
            end
            tb_time++;
        end
        if (n > 0)
            pending_records[$].last_rec = 1'b1;
    endfunction

    // Receiver backpressure
    always @(negedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(99) >= 7);
    end

    // Compare each record with the oldest expected one
    always @(posedge clk)
    begin
        record_t e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_records.size() == 0) begin
                $error("unexpected record id=%h port=%h", entry_id, entry_port);
                err_count++;
            end else begin
                e = pending_records.pop_front();
                if (record_kind !== e.kind) begin
                    $error("record_kind expected %0d actual %0d", e.kind, record_kind);
                    err_count++;
                end
                if (entry_id !== e.id) begin
                    $error("entry_id expected %h actual %h", e.id, entry_id);
                    err_count++;
                end
                if (entry_port !== e.port) begin
                    $error("entry_port expected %h actual %h", e.port, entry_port);
                    err_count++;
                end
                if (entry_beat !== e.beat) begin
                    $error("entry_beat expected %h actual %h", e.beat, entry_beat);
                    err_count++;
                end
                if (final_record !== e.last_rec) begin
                    $error("final_record expected %0d actual %0d", e.last_rec,
                           final_record);
                    err_count++;
                end
            end
        end
    end

    // Send one command transaction; called at a falling edge, returns at one
    task automatic send_cmd(cmd_t cmd, logic [31:0] id, logic [15:0] port,
                            logic [31:0] beat);
        in_valid   <= 1'b1;
        command    <= cmd;
        node_id    <= id;
        node_port  <= port;
        beat_count <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        predict_membership(cmd, id, port, beat);
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // Wait for all records, then let any silent work finish
    task automatic drain();
        int cyc;
        cyc = 0;
        in_valid <= 1'b0;
        while (pending_records.size() != 0 && cyc < DRAIN_LIMIT) begin
            @(negedge clk);
            cyc++;
        end
        if (pending_records.size() != 0) begin
            $error("%0d records never arrived", pending_records.size());
            err_count++;
            pending_records.delete();
        end
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Register write over the configuration port, block idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SELF_ID:   cfg_self_id = value;
            REG_SELF_PORT: cfg_self_port = value[15:0];
            REG_PERIOD:
            begin
                cfg_period   = value[7:0];
                tb_countdown = value[7:0];
            end
            REG_TIMEOUT:   cfg_timeout = value[15:0];
            REG_IN_GROUP:  tb_in_group = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(logic [31:0] sid, logic [15:0] sport, logic [7:0] period,
                             logic [15:0] timeout, logic grp);
        drain();
        write_reg(REG_SELF_ID, sid);
        write_reg(REG_SELF_PORT, {16'd0, sport});
        write_reg(REG_PERIOD, {24'd0, period});
        write_reg(REG_TIMEOUT, {16'd0, timeout});
        write_reg(REG_IN_GROUP, {31'd0, grp});
    endtask

    // Join, merge, dump and removal basics with field extremes
    task automatic test_directed();
        configure(32'h0000_0001, 16'h0001, 8'd1, 16'd4, 1'b0);
        // tick out of group is silent
        send_cmd(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_GOSSIP, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        send_cmd(CMD_GOSSIP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        // newer, equal and older heartbeats for a present node
        send_cmd(CMD_GOSSIP, 32'h0000_0000, 16'h0000, 32'h0000_0005);
        send_cmd(CMD_GOSSIP, 32'h0000_0000, 16'h0000, 32'h0000_0005);
        send_cmd(CMD_GOSSIP, 32'h0000_0000, 16'h0000, 32'h0000_0002);
        // join request from a new and a present node, self gets added
        send_cmd(CMD_JOIN_REQ, 32'hA5A5_5A5A, 16'h5A5A, 32'h0000_0007);
        send_cmd(CMD_JOIN_REQ, 32'hA5A5_5A5A, 16'h5A5A, 32'h0000_0009);
        // same id, other port is a different node
        send_cmd(CMD_JOIN_REP, 32'hA5A5_5A5A, 16'h1234, 32'h0000_0003);
        // ticks run dumps and the removal sweep
        repeat (8) send_cmd(CMD_TICK, $urandom, 16'($urandom), $urandom);
        // stale entry is not refreshed once past half the timeout
        send_cmd(CMD_GOSSIP, 32'h0000_0001, 16'h0001, 32'h0000_0010);
        send_cmd(CMD_GOSSIP, 32'h0BAD_F00D, 16'h0777, 32'h0000_0001);
        repeat (3) send_cmd(CMD_TICK, 32'd0, 16'd0, 32'd0);
        send_cmd(CMD_GOSSIP, 32'h0BAD_F00D, 16'h0777, 32'h0000_0002);
        send_cmd(CMD_JOIN_REQ, 32'h0BAD_F00D, 16'h0777, 32'h0000_0002);
    endtask

    // Fill the table past its capacity, then dump and sweep it
    task automatic test_full_table();
        configure(32'hFFFF_FFFF, 16'hFFFF, 8'd0, 16'd65535, 1'b1);
        for (int i = 0; i < SLOTS + 2; i++)
            send_cmd(CMD_GOSSIP, 32'h1000_0000 + i, i[15:0], $urandom);
        send_cmd(CMD_JOIN_REQ, 32'h2000_0000, 16'h0042, 32'd1);
        send_cmd(CMD_TICK, 32'd0, 16'd0, 32'd0);
        // zero timeout drops every non-self entry on the next sweep
        configure(32'hFFFF_FFFF, 16'hFFFF, 8'd255, 16'd0, 1'b1);
        send_cmd(CMD_TICK, 32'd0, 16'd0, 32'd0);
        send_cmd(CMD_TICK, 32'd0, 16'd0, 32'd0);
    endtask

    // Random mixes of joins, gossip and ticks over a small node pool
    task automatic test_random();
        int k;
        int sel;
        logic [31:0] beat;
        for (int i = 0; i < 8; i++) begin
            pool_id[i]   = $urandom;
            pool_port[i] = 16'($urandom);
        end
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: configure(pool_id[0], pool_port[0], 8'd2, 16'd6, 1'b0);
                1: configure(pool_id[1], pool_port[1], 8'd0, 16'd3, 1'b1);
                2: configure(32'd0, 16'd0, 8'd3, 16'd12, 1'b1);
                default: configure(pool_id[2], pool_port[2], 8'd1, 16'd65535, 1'b1);
            endcase
            no_idle = (ph == 2);
            for (int n = 0; n < 30; n++) begin
                k    = $urandom_range(7);
                sel  = $urandom_range(99);
                beat = $urandom_range(1) ? $urandom_range(40) : $urandom;
                if (sel < 35)
                    send_cmd(CMD_GOSSIP, pool_id[k], pool_port[k], beat);
                else if (sel < 45)
                    send_cmd(CMD_JOIN_REP, pool_id[k], pool_port[k], beat);
                else if (sel < 55)
                    send_cmd(CMD_JOIN_REQ, pool_id[k], pool_port[k], beat);
                else if (sel < 90)
                    send_cmd(CMD_TICK, $urandom, 16'($urandom), $urandom);
                else
                    send_cmd(cmd_t'($urandom_range(3)), $urandom, 16'($urandom),
                             $urandom);
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        err_count = 0;
        no_idle   = 1'b0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        command   = CMD_GOSSIP;
        node_id   = '0;
        node_port = '0;
        beat_count = '0;
        out_ready = 1'b1;
        // Shadow state after reset
        tb_fill       = 0;
        tb_time       = 32'hFFFF_FFFF;
        tb_own_beat   = '0;
        cfg_self_id   = '0;
        cfg_self_port = '0;
        cfg_period    = 8'd5;
        cfg_timeout   = 16'd20;
        tb_countdown  = 8'd5;
        tb_in_group   = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_full_table();
        test_random();
        drain();

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
